FILE: rtl/pid_pkg.sv
// ----------------------------------------------------------------------------
// PID package
// Shared sizes, register indexes and word types of the PID controller.
// ----------------------------------------------------------------------------
package pid_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int SUM_WIDTH_DEF = 48;
    localparam int GAIN_WIDTH    = 32;
    localparam int LIMIT_WIDTH   = 31;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_INDEX_W   = 3;

    // Angle mode works in degrees with the same fraction as the data.
    localparam int ANGLE_FULL = 360;
    localparam int ANGLE_HALF = 180;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE_INC   = 3'd0,
        CFG_ANGLE_WRAP = 3'd1,
        CFG_GAIN_P     = 3'd2,
        CFG_GAIN_I     = 3'd3,
        CFG_GAIN_D     = 3'd4,
        CFG_OUT_LIMIT  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] setpoint;
        logic signed [DATA_WIDTH-1:0] measured;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] drive;
        logic signed [DATA_WIDTH-1:0] error_now;
    } out_word_t;

    typedef struct packed {
        logic                         mode_incremental;
        logic                         angle_wrap;
        logic signed [GAIN_WIDTH-1:0] gain_p;
        logic signed [GAIN_WIDTH-1:0] gain_i;
        logic signed [GAIN_WIDTH-1:0] gain_d;
        logic [LIMIT_WIDTH-1:0]       out_limit;
    } cfg_t;

endpackage

FILE: rtl/pid_positional_incremental.sv
// Path: a word accepted into the input register passes through the error,
// operand, product, term and result registers to reach the result port.
// Throughput: one word per cycle while m_ready is high; the error history and
// the held output each close their loop within a single stage, so words follow
// back to back. Each stage holds its word while the next one is full, so a
// stalled result does not stop the input until all stages are occupied.
// Reset (sync, active low) clears config, history, held output and valid bits.
// ----------------------------------------------------------------------------
// PID controller, positional and incremental
// Top level: configuration registers, input register and stage handshake.
// ----------------------------------------------------------------------------
module pid_positional_incremental #(
    parameter int FRAC_BITS = pid_pkg::FRAC_BITS_DEF,
    parameter int SUM_WIDTH = pid_pkg::SUM_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  pid_pkg::in_word_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output pid_pkg::out_word_t               m_data,
    input  logic                             cfg_wr_en,
    input  logic [pid_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pid_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import pid_pkg::*;

    localparam int OP_W = (SUM_WIDTH > DATA_WIDTH + 2) ? SUM_WIDTH : DATA_WIDTH + 2;

    cfg_t     cfg_reg;
    in_word_t in_word_reg;

    // Valid bits of the input, error, operand, product, term and result stages.
    logic vld_in_reg, vld_err_reg, vld_op_reg, vld_pp_reg, vld_term_reg, vld_out_reg;
    logic rdy_in, rdy_err, rdy_op, rdy_pp, rdy_term, rdy_out;
    logic en_err, en_op, en_pp, en_term, en_out;

    logic signed [DATA_WIDTH-1:0] err_b;
    logic signed [DATA_WIDTH-1:0] err_c;
    logic signed [DATA_WIDTH-1:0] err_d_reg;
    logic signed [DATA_WIDTH-1:0] err_e_reg;
    logic signed [OP_W-1:0]       op_p, op_i, op_d;
    logic signed [DATA_WIDTH-1:0] term_p, term_i, term_d;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_MODE_INC:   cfg_reg.mode_incremental <= cfg_wdata[0];
                CFG_ANGLE_WRAP: cfg_reg.angle_wrap       <= cfg_wdata[0];
                CFG_GAIN_P:     cfg_reg.gain_p           <= $signed(cfg_wdata[GAIN_WIDTH-1:0]);
                CFG_GAIN_I:     cfg_reg.gain_i           <= $signed(cfg_wdata[GAIN_WIDTH-1:0]);
                CFG_GAIN_D:     cfg_reg.gain_d           <= $signed(cfg_wdata[GAIN_WIDTH-1:0]);
                CFG_OUT_LIMIT:  cfg_reg.out_limit        <= cfg_wdata[LIMIT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // A stage takes a new word when it is empty or its word moves on.
    assign rdy_out  = !vld_out_reg  || m_ready;
    assign rdy_term = !vld_term_reg || rdy_out;
    assign rdy_pp   = !vld_pp_reg   || rdy_term;
    assign rdy_op   = !vld_op_reg   || rdy_pp;
    assign rdy_err  = !vld_err_reg  || rdy_op;
    assign rdy_in   = !vld_in_reg   || rdy_err;

    assign en_err  = rdy_err  && vld_in_reg;
    assign en_op   = rdy_op   && vld_err_reg;
    assign en_pp   = rdy_pp   && vld_op_reg;
    assign en_term = rdy_term && vld_pp_reg;
    assign en_out  = rdy_out  && vld_term_reg;

    assign s_ready = rdy_in;
    assign m_valid = vld_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_in_reg   <= 1'b0;
            vld_err_reg  <= 1'b0;
            vld_op_reg   <= 1'b0;
            vld_pp_reg   <= 1'b0;
            vld_term_reg <= 1'b0;
            vld_out_reg  <= 1'b0;
        end else begin
            if (rdy_in)   vld_in_reg   <= s_valid;
            if (rdy_err)  vld_err_reg  <= vld_in_reg;
            if (rdy_op)   vld_op_reg   <= vld_err_reg;
            if (rdy_pp)   vld_pp_reg   <= vld_op_reg;
            if (rdy_term) vld_term_reg <= vld_pp_reg;
            if (rdy_out)  vld_out_reg  <= vld_term_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && rdy_in) begin
            in_word_reg <= s_data;
        end
        if (en_pp) begin
            err_d_reg <= err_c;
        end
        if (en_term) begin
            err_e_reg <= err_d_reg;
        end
    end

    pid_err #(
        .FRAC_BITS (FRAC_BITS)
    ) u_err (
        .aclk    (aclk),
        .en      (en_err),
        .in_word (in_word_reg),
        .cfg     (cfg_reg),
        .err     (err_b)
    );

    pid_hist #(
        .SUM_WIDTH (SUM_WIDTH),
        .OP_W      (OP_W)
    ) u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en_op),
        .cfg     (cfg_reg),
        .err_in  (err_b),
        .op_p    (op_p),
        .op_i    (op_i),
        .op_d    (op_d),
        .err_out (err_c)
    );

    pid_mul #(
        .OP_W      (OP_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul_p (
        .aclk    (aclk),
        .en_pp   (en_pp),
        .en_term (en_term),
        .operand (op_p),
        .gain    (cfg_reg.gain_p),
        .term    (term_p)
    );

    pid_mul #(
        .OP_W      (OP_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul_i (
        .aclk    (aclk),
        .en_pp   (en_pp),
        .en_term (en_term),
        .operand (op_i),
        .gain    (cfg_reg.gain_i),
        .term    (term_i)
    );

    pid_mul #(
        .OP_W      (OP_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul_d (
        .aclk    (aclk),
        .en_pp   (en_pp),
        .en_term (en_term),
        .operand (op_d),
        .gain    (cfg_reg.gain_d),
        .term    (term_d)
    );

    pid_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en_out),
        .cfg      (cfg_reg),
        .term_p   (term_p),
        .term_i   (term_i),
        .term_d   (term_d),
        .err      (err_e_reg),
        .out_word (m_data)
    );

endmodule

FILE: rtl/pid_err.sv
// ----------------------------------------------------------------------------
// PID error stage
// Forms the saturated error of one word, with optional angle folding.
// ----------------------------------------------------------------------------
module pid_err #(
    parameter int FRAC_BITS = pid_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 en,
    input  pid_pkg::in_word_t                    in_word,
    input  pid_pkg::cfg_t                        cfg,
    output logic signed [pid_pkg::DATA_WIDTH-1:0] err
);
    import pid_pkg::*;

    localparam int AW = ((DATA_WIDTH > FRAC_BITS + 9) ? DATA_WIDTH : FRAC_BITS + 9) + 3;
    localparam logic signed [AW-1:0] FULL  = AW'(ANGLE_FULL) <<< FRAC_BITS;
    localparam logic signed [AW-1:0] HALF  = AW'(ANGLE_HALF) <<< FRAC_BITS;
    localparam logic signed [AW-1:0] E_MAX = (AW'(1) <<< (DATA_WIDTH - 1)) - AW'(1);
    localparam logic signed [AW-1:0] E_MIN = -E_MAX - AW'(1);

    logic signed [AW-1:0]         sp_fold;
    logic signed [AW-1:0]         diff;
    logic signed [DATA_WIDTH-1:0] err_next;
    logic signed [DATA_WIDTH-1:0] err_reg;

    always_comb begin
        sp_fold = AW'(in_word.setpoint);
        if (cfg.angle_wrap) begin
            // Only one fold is made, so a target far out of range stays out.
            if (sp_fold > FULL) begin
                sp_fold = sp_fold - FULL;
            end else if (sp_fold < 0) begin
                sp_fold = sp_fold + FULL;
            end
        end
        diff = sp_fold - AW'(in_word.measured);
        if (cfg.angle_wrap) begin
            if (diff > HALF) begin
                diff = diff - FULL;
            end else if (diff < -HALF) begin
                diff = diff + FULL;
            end
        end
        if (diff > E_MAX) begin
            err_next = DATA_WIDTH'(E_MAX);
        end else if (diff < E_MIN) begin
            err_next = DATA_WIDTH'(E_MIN);
        end else begin
            err_next = DATA_WIDTH'(diff);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            err_reg <= err_next;
        end
    end

    assign err = err_reg;

endmodule

FILE: rtl/pid_hist.sv
// ----------------------------------------------------------------------------
// PID history stage
// Keeps the error history and the error sum, and picks the three operands
// that the gains multiply in the selected form.
// ----------------------------------------------------------------------------
module pid_hist #(
    parameter int SUM_WIDTH = pid_pkg::SUM_WIDTH_DEF,
    parameter int OP_W      = pid_pkg::SUM_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  pid_pkg::cfg_t                        cfg,
    input  logic signed [pid_pkg::DATA_WIDTH-1:0] err_in,
    output logic signed [OP_W-1:0]               op_p,
    output logic signed [OP_W-1:0]               op_i,
    output logic signed [OP_W-1:0]               op_d,
    output logic signed [pid_pkg::DATA_WIDTH-1:0] err_out
);
    import pid_pkg::*;

    localparam logic signed [SUM_WIDTH-1:0] S_MAX = {1'b0, {(SUM_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] S_MIN = {1'b1, {(SUM_WIDTH - 1){1'b0}}};

    logic signed [DATA_WIDTH-1:0] prev_error_reg;
    logic signed [DATA_WIDTH-1:0] prev2_error_reg;
    logic signed [SUM_WIDTH-1:0]  error_sum_reg;
    logic signed [SUM_WIDTH:0]    sum_wide;
    logic signed [SUM_WIDTH-1:0]  error_sum_next;
    logic signed [OP_W-1:0]       d1;
    logic signed [OP_W-1:0]       d2;
    logic signed [OP_W-1:0]       op_p_reg, op_p_next;
    logic signed [OP_W-1:0]       op_i_reg, op_i_next;
    logic signed [OP_W-1:0]       op_d_reg, op_d_next;
    logic signed [DATA_WIDTH-1:0] err_reg;

    always_comb begin
        sum_wide = (SUM_WIDTH + 1)'(error_sum_reg) + (SUM_WIDTH + 1)'(err_in);
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
            error_sum_next = sum_wide[SUM_WIDTH] ? S_MIN : S_MAX;
        end else begin
            error_sum_next = SUM_WIDTH'(sum_wide);
        end

        // Differences enter the products at full width, unsaturated.
        d1 = OP_W'(err_in) - OP_W'(prev_error_reg);
        d2 = OP_W'(err_in) - (OP_W'(prev_error_reg) <<< 1) + OP_W'(prev2_error_reg);

        if (cfg.mode_incremental) begin
            op_p_next = d1;
            op_i_next = OP_W'(err_in);
            op_d_next = d2;
        end else begin
            op_p_next = OP_W'(err_in);
            op_i_next = OP_W'(error_sum_next);
            op_d_next = d1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_error_reg  <= '0;
            prev2_error_reg <= '0;
            error_sum_reg   <= '0;
        end else if (en) begin
            prev_error_reg <= err_in;
            if (cfg.mode_incremental) begin
                prev2_error_reg <= prev_error_reg;
            end else begin
                error_sum_reg <= error_sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_p_reg <= op_p_next;
            op_i_reg <= op_i_next;
            op_d_reg <= op_d_next;
            err_reg  <= err_in;
        end
    end

    assign op_p    = op_p_reg;
    assign op_i    = op_i_reg;
    assign op_d    = op_d_reg;
    assign err_out = err_reg;

endmodule

FILE: rtl/pid_mul.sv
// ----------------------------------------------------------------------------
// PID gain multiplier
// Two-stage signed multiply of an operand by a gain, scaled down by the
// fraction with truncation toward zero and saturated to the data width.
// ----------------------------------------------------------------------------
module pid_mul #(
    parameter int OP_W      = pid_pkg::SUM_WIDTH_DEF,
    parameter int FRAC_BITS = pid_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  en_pp,
    input  logic                                  en_term,
    input  logic signed [OP_W-1:0]                operand,
    input  logic signed [pid_pkg::GAIN_WIDTH-1:0] gain,
    output logic signed [pid_pkg::DATA_WIDTH-1:0] term
);
    import pid_pkg::*;

    localparam int LO_W = OP_W / 2;
    localparam int HI_W = OP_W - LO_W;
    localparam int PW   = OP_W + GAIN_WIDTH;
    localparam logic signed [PW-1:0] RND   = (PW'(1) <<< FRAC_BITS) - PW'(1);
    localparam logic signed [PW-1:0] T_MAX = (PW'(1) <<< (DATA_WIDTH - 1)) - PW'(1);
    localparam logic signed [PW-1:0] T_MIN = -T_MAX - PW'(1);

    logic signed [LO_W+GAIN_WIDTH:0]   pp_lo_reg;
    logic signed [HI_W+GAIN_WIDTH-1:0] pp_hi_reg;
    logic signed [PW-1:0]              full;
    logic signed [PW-1:0]              scaled;
    logic signed [DATA_WIDTH-1:0]      term_next;
    logic signed [DATA_WIDTH-1:0]      term_reg;

    // The operand is split in two halves so that each product stays narrow.
    always_ff @(posedge aclk) begin
        if (en_pp) begin
            pp_lo_reg <= $signed({1'b0, operand[LO_W-1:0]}) * gain;
            pp_hi_reg <= $signed(operand[OP_W-1:LO_W]) * gain;
        end
    end

    always_comb begin
        full = (PW'(pp_hi_reg) <<< LO_W) + PW'(pp_lo_reg);
        // Biasing a negative product before the shift rounds toward zero.
        scaled = (full + (full[PW-1] ? RND : PW'(0))) >>> FRAC_BITS;
        if (scaled > T_MAX) begin
            term_next = DATA_WIDTH'(T_MAX);
        end else if (scaled < T_MIN) begin
            term_next = DATA_WIDTH'(T_MIN);
        end else begin
            term_next = DATA_WIDTH'(scaled);
        end
    end

    always_ff @(posedge aclk) begin
        if (en_term) begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

FILE: rtl/pid_out.sv
// ----------------------------------------------------------------------------
// PID output stage
// Adds the three terms (and the held output in incremental form), saturates,
// clamps to the limit and keeps the result as the held output.
// ----------------------------------------------------------------------------
module pid_out (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  pid_pkg::cfg_t                        cfg,
    input  logic signed [pid_pkg::DATA_WIDTH-1:0] term_p,
    input  logic signed [pid_pkg::DATA_WIDTH-1:0] term_i,
    input  logic signed [pid_pkg::DATA_WIDTH-1:0] term_d,
    input  logic signed [pid_pkg::DATA_WIDTH-1:0] err,
    output pid_pkg::out_word_t                   out_word
);
    import pid_pkg::*;

    localparam int TW = DATA_WIDTH + 3;
    localparam logic signed [TW-1:0] O_MAX = (TW'(1) <<< (DATA_WIDTH - 1)) - TW'(1);
    localparam logic signed [TW-1:0] O_MIN = -O_MAX - TW'(1);

    logic signed [DATA_WIDTH-1:0] held_output_reg;
    logic signed [TW-1:0]         total;
    logic signed [TW-1:0]         total_sat;
    logic signed [TW-1:0]         lim;
    logic signed [TW-1:0]         clamped;
    logic signed [DATA_WIDTH-1:0] drive_next;
    out_word_t                    out_word_reg;

    always_comb begin
        total = TW'(term_p) + TW'(term_i) + TW'(term_d)
              + (cfg.mode_incremental ? TW'(held_output_reg) : TW'(0));
        if (total > O_MAX) begin
            total_sat = O_MAX;
        end else if (total < O_MIN) begin
            total_sat = O_MIN;
        end else begin
            total_sat = total;
        end
        lim = TW'(cfg.out_limit);
        if (total_sat > lim) begin
            clamped = lim;
        end else if (total_sat < -lim) begin
            clamped = -lim;
        end else begin
            clamped = total_sat;
        end
        drive_next = DATA_WIDTH'(clamped);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_output_reg <= '0;
        end else if (en) begin
            held_output_reg <= drive_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_word_reg.drive     <= drive_next;
            out_word_reg.error_now <= err;
        end
    end

    assign out_word = out_word_reg;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID controller testbench
// Drives random and directed samples through the positional and incremental
// forms, with and without angle mode, under several gain and clamp settings.
// A bit-true controller in the bench predicts every result word.
// ----------------------------------------------------------------------------
module tb;
    import pid_pkg::*;

    localparam int     FRAC          = FRAC_BITS_DEF;
    localparam int     SUMW          = SUM_WIDTH_DEF;
    localparam int     DEG           = 1 << FRAC;
    localparam longint DATA_MAX      = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    localparam longint SUM_MAX       = (longint'(1) <<< (SUMW - 1)) - 1;
    localparam longint TURN          = longint'(ANGLE_FULL) <<< FRAC;
    localparam longint HALF_TURN     = longint'(ANGLE_HALF) <<< FRAC;
    localparam int     DRAIN_CYCLES  = 12;
    localparam int     HOLD_AT       = 400;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     QUIET_LIMIT   = 5000;
    localparam int     PRINT_LIMIT   = 50;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_word_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_word_t              m_data;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    pid_positional_incremental dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Controller copy: settings and loop state.
    bit     cfg_mode_inc = 1'b0;
    bit     cfg_angle    = 1'b0;
    longint gain_prop    = 0;
    longint gain_int     = 0;
    longint gain_der     = 0;
    longint out_lim      = 0;
    longint prev_err     = 0;
    longint prev2_err    = 0;
    longint err_sum      = 0;
    longint held_out     = 0;

    in_word_t  pending_samples[$];
    out_word_t expected_outputs[$];
    out_word_t want;
    int        mismatches  = 0;
    int        words_sent  = 0;
    int        gap_left    = 0;
    int        burst_left  = 0;
    int        hold_left   = 0;
    bit        hold_done   = 1'b0;
    int        rx_cycle    = 0;
    int        quiet       = 0;

    function automatic longint clamp_to(longint x, longint hi);
        if (x > hi) return hi;
        if (x < -hi - 1) return -hi - 1;
        return x;
    endfunction

    // Full-precision product, scaled down toward zero, saturated to the data width.
    function automatic longint gain_term(longint opnd, longint gain);
        logic signed [127:0] a_w;
        logic signed [127:0] g_w;
        logic signed [127:0] prod;
        logic signed [127:0] mag;
        a_w  = opnd;
        g_w  = gain;
        prod = a_w * g_w;
        mag  = (prod < 0) ? -prod : prod;
        mag  = mag >>> FRAC;
        if (prod < 0) mag = -mag;
        if (mag > DATA_MAX) return DATA_MAX;
        if (mag < -DATA_MAX - 1) return -DATA_MAX - 1;
        return longint'(mag);
    endfunction

    function automatic out_word_t control_step(in_word_t smp);
        longint    sp;
        longint    ms;
        longint    diff;
        longint    e;
        longint    total;
        out_word_t r;
        sp = smp.setpoint;
        ms = smp.measured;
        if (cfg_angle) begin
            // Only one fold of the target; a far-out target stays out of range.
            if (sp > TURN) sp -= TURN;
            else if (sp < 0) sp += TURN;
        end
        diff = sp - ms;
        if (cfg_angle) begin
            if (diff > HALF_TURN) diff -= TURN;
            else if (diff < -HALF_TURN) diff += TURN;
        end
        e = clamp_to(diff, DATA_MAX);
        if (cfg_mode_inc) begin
            total = gain_term(e - prev_err, gain_prop) + gain_term(e, gain_int)
                  + gain_term(e - 2 * prev_err + prev2_err, gain_der) + held_out;
            prev2_err = prev_err;
        end else begin
            err_sum = clamp_to(err_sum + e, SUM_MAX);
            total = gain_term(e, gain_prop) + gain_term(err_sum, gain_int)
                  + gain_term(e - prev_err, gain_der);
        end
        prev_err = e;
        total = clamp_to(total, DATA_MAX);
        if (total > out_lim) total = out_lim;
        else if (total < -out_lim) total = -out_lim;
        held_out    = total;
        r.drive     = held_out[DATA_WIDTH-1:0];
        r.error_now = e[DATA_WIDTH-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what);
        if (mismatches < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_MODE_INC:   cfg_mode_inc = val[0];
            CFG_ANGLE_WRAP: cfg_angle    = val[0];
            CFG_GAIN_P:     gain_prop    = longint'(signed'(val));
            CFG_GAIN_I:     gain_int     = longint'(signed'(val));
            CFG_GAIN_D:     gain_der     = longint'(signed'(val));
            CFG_OUT_LIMIT:  out_lim      = longint'(val[LIMIT_WIDTH-1:0]);
            default: ;
        endcase
    endtask

    task automatic apply_settings(bit mode, bit angle, logic [31:0] gp, logic [31:0] gi,
                                  logic [31:0] gd, logic [31:0] lim);
        write_reg(CFG_MODE_INC, {31'd0, mode});
        write_reg(CFG_ANGLE_WRAP, {31'd0, angle});
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
        write_reg(CFG_OUT_LIMIT, lim);
    endtask

    task automatic add_sample(logic [31:0] sp, logic [31:0] ms);
        in_word_t w;
        w.setpoint = sp;
        w.measured = ms;
        pending_samples.push_back(w);
    endtask

    // Checked on the falling edge so that no handshake of this cycle is missed.
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_samples.size() != 0 || s_valid || expected_outputs.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_gain();
        int mag;
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return 32'd0;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            default: begin
                mag = $urandom_range(0, 4 * DEG);
                return $urandom_range(0, 1) ? -mag : mag;
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return $urandom();
            default: return $urandom_range(1, 2000 * DEG);
        endcase
    endfunction

    function automatic in_word_t random_sample();
        in_word_t w;
        int       base;
        case ($urandom_range(0, 3))
            0: begin
                w.setpoint = $urandom();
                w.measured = $urandom();
            end
            1: begin
                // Measurement tracking close to the target.
                base       = $urandom();
                w.setpoint = base;
                w.measured = base + int'($urandom_range(0, 2 * DEG)) - DEG;
            end
            2: begin
                w.setpoint = int'($urandom_range(0, 1800 * DEG)) - 720 * DEG;
                w.measured = int'($urandom_range(0, 1800 * DEG)) - 720 * DEG;
            end
            default: begin
                w.setpoint = int'($urandom_range(0, 200 * DEG)) - 100 * DEG;
                w.measured = int'($urandom_range(0, 200 * DEG)) - 100 * DEG;
            end
        endcase
        return w;
    endfunction

    // Sender: bursts of words with random gaps, fed from the pending queue.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
            words_sent <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_outputs.push_back(control_step(s_data));
                words_sent <= words_sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    s_data  <= pending_samples.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: one long hold-off once traffic is flowing, otherwise a
    // rotating mix of full rate, random and periodic stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
            rx_cycle  <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (!hold_done && words_sent >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                case (rx_cycle[9:7])
                    3'd0, 3'd3: m_ready <= 1'b1;
                    3'd1:       m_ready <= ($urandom_range(0, 3) != 0);
                    3'd2:       m_ready <= (rx_cycle[2:0] != 3'd5);
                    default:    m_ready <= $urandom_range(0, 1);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected word drive=%h error=%h",
                                          m_data.drive, m_data.error_now));
            end else begin
                want = expected_outputs.pop_front();
                if (m_data.drive !== want.drive)
                    report_mismatch($sformatf("drive %h, expected %h",
                                              m_data.drive, want.drive));
                if (m_data.error_now !== want.error_now)
                    report_mismatch($sformatf("error_now %h, expected %h",
                                              m_data.error_now, want.error_now));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Field extremes and error saturation, positional form.
        apply_settings(1'b0, 1'b0, DEG, DEG / 2, 2 * DEG, 32'h7FFF_FFFF);
        add_sample(32'd0, 32'd0);
        add_sample(32'h7FFF_FFFF, 32'h8000_0000);
        add_sample(32'h8000_0000, 32'h7FFF_FFFF);
        add_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_sample(32'd1, -1);
        add_sample(DEG, 32'd0);
        wait_idle();

        // Extreme gains in the incremental form: the products saturate.
        apply_settings(1'b1, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                       32'h7FFF_FFFF);
        add_sample(32'h7FFF_FFFF, 32'h8000_0000);
        add_sample(32'h8000_0000, 32'h7FFF_FFFF);
        add_sample(32'h7FFF_FFFF, 32'h8000_0000);
        add_sample(32'd0, 32'd0);
        add_sample(5 * DEG, 3 * DEG);
        wait_idle();

        // Angle mode: folding up and down, shortest path both ways, a target
        // too far out for one fold, and the exact boundaries.
        apply_settings(1'b0, 1'b1, DEG, 32'd0, 32'd0, 1000 * DEG);
        add_sample(400 * DEG, 10 * DEG);
        add_sample(-30 * DEG, 10 * DEG);
        add_sample(10 * DEG, 350 * DEG);
        add_sample(800 * DEG, 32'd0);
        add_sample(360 * DEG, 32'd0);
        add_sample(32'd0, 180 * DEG);
        add_sample(180 * DEG, 32'd0);
        add_sample(32'h8000_0000, 32'h7FFF_FFFF);
        wait_idle();

        // Zero clamp: drive stays at zero while the state still moves.
        apply_settings(1'b1, 1'b1, 3 * DEG, -DEG, DEG, 32'd0);
        add_sample(100 * DEG, 32'd0);
        add_sample(-50 * DEG, 20 * DEG);
        add_sample(32'h7FFF_FFFF, 32'h8000_0000);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            apply_settings((p < 4) ? p[0] : 1'($urandom_range(0, 1)),
                           (p < 4) ? p[1] : 1'($urandom_range(0, 1)),
                           pick_gain(), pick_gain(), pick_gain(),
                           (p == 0) ? 32'h7FFF_FFFF : pick_limit());
            for (int i = 0; i < 125; i++) pending_samples.push_back(random_sample());
            wait_idle();
        end

        // Integral accumulation with the largest errors, first upward, then
        // downward past zero, then back up. A unit integral gain makes the
        // upper bits of the sum visible on drive.
        apply_settings(1'b0, 1'b0, 32'd0, 32'd1, 32'd0, 32'h7FFF_FFFF);
        for (int i = 0; i < 6; i++) add_sample(32'h7FFF_FFFF, 32'h8000_0000);
        for (int i = 0; i < 12; i++) add_sample(32'h8000_0000, 32'h7FFF_FFFF);
        for (int i = 0; i < 4; i++) add_sample(32'h7FFF_FFFF, 32'h8000_0000);
        wait_idle();

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_outputs.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

FILE: files.f
rtl/pid_pkg.sv
rtl/pid_err.sv
rtl/pid_hist.sv
rtl/pid_mul.sv
rtl/pid_out.sv
rtl/pid_positional_incremental.sv
tb/tb.sv
